// ===== rtl/core/mpse_pkg.sv =====
// Shared types and constants for the MessagePack scalar encoder.
// No dependencies.
package mpse_pkg;
   typedef enum logic [2:0] {
      MODE_NIL  = 3'd0,
      MODE_BOOL = 3'd1,
      MODE_INT  = 3'd2,
      MODE_DBL  = 3'd3,
      MODE_STR  = 3'd4
   } mode_type;

   localparam logic [7:0] TAG_NIL    = 8'hc0;
   localparam logic [7:0] TAG_FALSE  = 8'hc2;
   localparam logic [7:0] TAG_TRUE   = 8'hc3;
   localparam logic [7:0] TAG_FLT32  = 8'hca;
   localparam logic [7:0] TAG_FLT64  = 8'hcb;
   localparam logic [7:0] TAG_UINT8  = 8'hcc;
   localparam logic [7:0] TAG_UINT16 = 8'hcd;
   localparam logic [7:0] TAG_UINT32 = 8'hce;
   localparam logic [7:0] TAG_INT8   = 8'hd0;
   localparam logic [7:0] TAG_INT16  = 8'hd1;
   localparam logic [7:0] TAG_INT32  = 8'hd2;
   localparam logic [7:0] TAG_INT64  = 8'hd3;
   localparam logic [7:0] TAG_STR8   = 8'hd9;
   localparam logic [7:0] TAG_STR16  = 8'hda;
   localparam logic [7:0] TAG_STR32  = 8'hdb;
   localparam logic [7:0] TAG_FIXSTR = 8'ha0;

   // Classified job: header byte, payload bytes (0..8), payload left-aligned.
   typedef struct packed {
      logic [7:0]  head;
      logic [3:0]  nbytes;
      logic [63:0] payload;
      logic        err;
   } job_type;
endpackage

// ===== rtl/core/msgpack_scalar_encoder.sv =====
// MessagePack scalar encoder: one scalar in, its encoded bytes out, one byte per
// cycle unless rsp_tready stalls it. An item yields 1 to 9 bytes from the back
// end's serializer; the front end classifies the next item meanwhile. Modes 5-7
// produce no output. Depends on mpse_pkg, mpse_front, mpse_queue, mpse_back.
module msgpack_scalar_encoder
   import mpse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // [2:0] mode, [66:3] value, [71:67] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser   // [0] too_long
);
   logic    f_valid, f_ready, q_valid, q_ready;
   job_type f_job, q_job;

   mpse_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_mode(req_tdata[2:0]), .in_value(req_tdata[66:3]),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   mpse_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_job(q_job)
   );

   mpse_back u_back (
      .clock, .reset,
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_byte(rsp_tdata), .out_last(rsp_tlast), .out_err(rsp_tuser)
   );
endmodule

// ===== rtl/core/mpse_front.sv =====
// Front end: accepts scalar words and classifies them into byte jobs.
// Depends on mpse_pkg.
module mpse_front
   import mpse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [2:0]  in_mode,
   input  logic [63:0] in_value,
   output logic        job_valid,
   input  logic        job_ready,
   output job_type     job
);
   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    take;

   logic [63:0] v;
   logic        neg, ok32;
   logic [10:0] ex;
   logic [51:0] man;
   logic [31:0] f32;
   logic [52:0] full;
   logic [5:0]  sh;
   logic [52:0] mask;

   assign v        = in_value;
   assign in_ready = !valid_ff || job_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      ex   = v[62:52];
      man  = v[51:0];
      full = {1'b1, man};
      sh   = 6'd0;
      mask = '0;
      ok32 = 1'b0;
      f32  = '0;
      if (ex == 11'h7ff) begin
         ok32 = (man == '0);
         f32  = {v[63], 8'hff, 23'd0};
      end else if (ex == 11'd0) begin
         ok32 = (man == '0);
         f32  = {v[63], 31'd0};
      end else if (ex >= 11'd897 && ex <= 11'd1150) begin
         ok32 = (man[28:0] == '0);
         f32  = {v[63], 8'(ex - 11'd896), man[51:29]};
      end else if (ex >= 11'd874 && ex < 11'd897) begin
         sh   = 6'(11'd926 - ex);
         mask = (53'd1 << sh) - 53'd1;
         ok32 = ((full & mask) == '0);
         f32  = {v[63], 31'(full >> sh)};
      end
   end

   always_comb begin
      neg    = v[63];
      job_in = '{head: TAG_NIL, nbytes: 4'd0, payload: 64'd0, err: 1'b0};
      case (mode_type'(in_mode))
         MODE_NIL:  job_in.head = TAG_NIL;
         MODE_BOOL: job_in.head = v[0] ? TAG_TRUE : TAG_FALSE;
         MODE_INT: begin
            if (!neg && v <= 64'h7f) job_in.head = v[7:0];
            else if (!neg && v <= 64'hff)
               job_in = '{TAG_UINT8, 4'd1, {v[7:0], 56'd0}, 1'b0};
            else if (!neg && v <= 64'hffff)
               job_in = '{TAG_UINT16, 4'd2, {v[15:0], 48'd0}, 1'b0};
            else if (!neg && v <= 64'hffff_ffff)
               job_in = '{TAG_UINT32, 4'd4, {v[31:0], 32'd0}, 1'b0};
            else if (neg && v >= 64'hffff_ffff_ffff_ffe0) job_in.head = v[7:0];
            else if (neg && v >= 64'hffff_ffff_ffff_ff80)
               job_in = '{TAG_INT8, 4'd1, {v[7:0], 56'd0}, 1'b0};
            else if (neg && v >= 64'hffff_ffff_ffff_8000)
               job_in = '{TAG_INT16, 4'd2, {v[15:0], 48'd0}, 1'b0};
            else if (neg && v >= 64'hffff_ffff_8000_0000)
               job_in = '{TAG_INT32, 4'd4, {v[31:0], 32'd0}, 1'b0};
            else
               job_in = '{TAG_INT64, 4'd8, v, 1'b0};
         end
         MODE_DBL: begin
            if (ok32) job_in = '{TAG_FLT32, 4'd4, {f32, 32'd0}, 1'b0};
            else      job_in = '{TAG_FLT64, 4'd8, v, 1'b0};
         end
         MODE_STR: begin
            if (v <= 64'd31) job_in.head = TAG_FIXSTR + v[7:0];
            else if (v <= 64'hff)
               job_in = '{TAG_STR8, 4'd1, {v[7:0], 56'd0}, 1'b0};
            else if (v <= 64'hffff)
               job_in = '{TAG_STR16, 4'd2, {v[15:0], 48'd0}, 1'b0};
            else if (v <= 64'hffff_ffff)
               job_in = '{TAG_STR32, 4'd4, {v[31:0], 32'd0}, 1'b0};
            else
               job_in = '{8'h00, 4'd0, 64'd0, 1'b1};
         end
         default: job_in = '{TAG_NIL, 4'd0, 64'd0, 1'b0};
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (job_ready) valid_in = 1'b0;
      if (take) valid_in = (in_mode <= 3'(MODE_STR));
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      if (take)  job_ff <= job_in;
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;
endmodule

// ===== rtl/core/mpse_queue.sv =====
// Two-entry job queue between front and back.
// Depends on mpse_pkg.
module mpse_queue
   import mpse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  job_type wr_job,
   output logic    rd_valid,
   input  logic    rd_ready,
   output job_type rd_job
);
   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr, rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign wr       = wr_valid && wr_ready;
   assign rd       = rd_valid && rd_ready;
   assign rd_job   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wr ? !wp_ff : wp_ff;
      rp_in  = rd ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(wr) - 2'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr) mem_ff[wp_ff] <= wr_job;
   end
endmodule

// ===== rtl/core/mpse_back.sv =====
// Back end: serializes a job into bytes, header first, with an output register.
// Depends on mpse_pkg.
module mpse_back
   import mpse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   output logic       job_ready,
   input  job_type    job,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_last,
   output logic       out_err
);
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in, err_ff, err_in;
   logic [3:0] idx_ff, idx_in;
   logic       adv, fin;
   logic [7:0] cur;

   assign adv = !valid_ff || out_ready;
   always_comb begin
      cur = job.head;
      if (idx_ff != 4'd0) cur = job.payload[63 - 8*(idx_ff - 4'd1) -: 8];
   end
   assign fin       = (idx_ff == job.nbytes);
   assign job_ready = adv && job_valid && fin;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      idx_in   = idx_ff;
      if (adv) begin
         valid_in = job_valid;
         byte_in  = cur;
         last_in  = fin;
         err_in   = job.err;
         if (job_valid) idx_in = fin ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_err   = err_ff;
endmodule

// ===== rtl/core/mpse_checker.sv =====
// Port-level checks for the MessagePack scalar encoder, bound to the top level.
// Depends on msgpack_scalar_encoder.
module mpse_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == 8'h00)
      else $error("error word not a lone zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled word changed");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("valid after reset");
endmodule

bind msgpack_scalar_encoder mpse_checker u_mpse_checker (.*);

// ===== test/tb_msgpack_scalar_encoder.sv =====
// Testbench for msgpack_scalar_encoder: drives scalar words, predicts the
// encoded byte stream and checks every output word. Depends on mpse_pkg and msgpack_scalar_encoder.
`timescale 1ns / 100ps
module tb_msgpack_scalar_encoder;
   import mpse_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       too_long;
   } enc_byte_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   enc_byte_type pending_bytes[$];
   int           error_count = 0;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           quiet_cycles;

   msgpack_scalar_encoder u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void push_byte(input logic [7:0] b);
      enc_byte_type e;
      e.data = b;
      e.last = 1'b0;
      e.too_long = 1'b0;
      pending_bytes.push_back(e);
   endfunction

   function automatic void push_be(input logic [63:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) push_byte(v[8*i +: 8]);
   endfunction

   function automatic void encode_int(input logic [63:0] v);
      if (!v[63]) begin
         if (v <= 64'h7f) push_byte(v[7:0]);
         else if (v <= 64'hff) begin push_byte(TAG_UINT8); push_be(v, 1); end
         else if (v <= 64'hffff) begin push_byte(TAG_UINT16); push_be(v, 2); end
         else if (v <= 64'hffffffff) begin push_byte(TAG_UINT32); push_be(v, 4); end
         else begin push_byte(TAG_INT64); push_be(v, 8); end
      end else begin
         if (v >= 64'hffffffffffffffe0) push_byte(v[7:0]);
         else if (v >= 64'hffffffffffffff80) begin push_byte(TAG_INT8); push_be(v, 1); end
         else if (v >= 64'hffffffffffff8000) begin push_byte(TAG_INT16); push_be(v, 2); end
         else if (v >= 64'hffffffff80000000) begin push_byte(TAG_INT32); push_be(v, 4); end
         else begin push_byte(TAG_INT64); push_be(v, 8); end
      end
   endfunction

   function automatic void encode_double(input logic [63:0] v);
      logic [10:0] ex;
      logic [51:0] man;
      logic [52:0] full;
      logic [31:0] f;
      int          e;
      int          sh;
      bit          fits;
      ex = v[62:52];
      man = v[51:0];
      e = int'(ex) - 1023;
      fits = 1'b0;
      f = {v[63], 31'd0};
      if (ex == 11'h7ff) begin
         fits = (man == 0);
         f[30:23] = 8'hff;
      end else if (ex == 0) begin
         fits = (man == 0);
      end else if (e >= -126 && e <= 127) begin
         fits = (man[28:0] == 0);
         f[30:23] = 8'(e + 127);
         f[22:0] = man[51:29];
      end else if (e >= -149 && e < -126) begin
         sh = -97 - e;
         full = {1'b1, man};
         fits = ((full & ((53'd1 << sh) - 53'd1)) == 0);
         f[30:0] = 31'(full >> sh);
      end
      if (fits) begin push_byte(TAG_FLT32); push_be({32'd0, f}, 4); end
      else begin push_byte(TAG_FLT64); push_be(v, 8); end
   endfunction

   function automatic void predict_encoding(input logic [2:0] mode, input logic [63:0] v);
      int before_n;
      enc_byte_type e;
      before_n = pending_bytes.size();
      case (mode)
         MODE_NIL: push_byte(TAG_NIL);
         MODE_BOOL: push_byte(v[0] ? TAG_TRUE : TAG_FALSE);
         MODE_INT: encode_int(v);
         MODE_DBL: encode_double(v);
         MODE_STR: begin
            if (v <= 64'd31) push_byte(TAG_FIXSTR + v[7:0]);
            else if (v <= 64'hff) begin push_byte(TAG_STR8); push_be(v, 1); end
            else if (v <= 64'hffff) begin push_byte(TAG_STR16); push_be(v, 2); end
            else if (v <= 64'hffffffff) begin push_byte(TAG_STR32); push_be(v, 4); end
            else begin
               push_byte(8'h00);
               e = pending_bytes.pop_back();
               e.too_long = 1'b1;
               pending_bytes.push_back(e);
            end
         end
         default: ;
      endcase
      if (pending_bytes.size() > before_n) begin
         e = pending_bytes.pop_back();
         e.last = 1'b1;
         pending_bytes.push_back(e);
      end
   endfunction

   task automatic send_scalar(input logic [2:0] mode, input logic [63:0] v);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, v, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_encoding(mode, v);
   endtask

   always @(posedge clock) begin
      enc_byte_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_bytes.size() == 0) report("unexpected word", 64'(rsp_tdata), 64'd0);
            else begin
               want = pending_bytes.pop_front();
               if (rsp_tdata !== want.data)
                  report("out_byte", 64'(rsp_tdata), 64'(want.data));
               if (rsp_tlast !== want.last)
                  report("last_byte", 64'(rsp_tlast), 64'(want.last));
               if (rsp_tuser !== want.too_long)
                  report("too_long", 64'(rsp_tuser), 64'(want.too_long));
            end
         end
         if (quiet_cycles > 5000) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      send_scalar(MODE_NIL, 64'd0);
      send_scalar(MODE_BOOL, 64'd1);
      send_scalar(MODE_BOOL, 64'hfffffffffffffffe);
      send_scalar(MODE_INT, 64'd127);
      send_scalar(MODE_INT, 64'd128);
      send_scalar(MODE_INT, 64'h10000);
      send_scalar(MODE_INT, 64'h100000000);
      send_scalar(MODE_INT, 64'hffffffffffffffe0);
      send_scalar(MODE_INT, 64'hffffffffffffffdf);
      send_scalar(MODE_INT, 64'hffffffff7fffffff);
      send_scalar(MODE_INT, 64'h8000000000000000);
      send_scalar(MODE_DBL, 64'h3ff0000000000000);
      send_scalar(MODE_DBL, 64'h7ff8000000000001);
      send_scalar(MODE_DBL, 64'hfff0000000000000);
      send_scalar(MODE_DBL, 64'h8000000000000000);
      send_scalar(MODE_DBL, 64'h0000000000000001);
      send_scalar(MODE_DBL, 64'h36a0000000000000);
      send_scalar(MODE_DBL, 64'h3ff0000000000001);
      send_scalar(MODE_STR, 64'd31);
      send_scalar(MODE_STR, 64'd32);
      send_scalar(MODE_STR, 64'h1234);
      send_scalar(MODE_STR, 64'hffffffff);
      send_scalar(MODE_STR, 64'hffffffffffffffff);
      send_scalar(3'd5, 64'd7);
      send_scalar(3'd7, 64'hffffffffffffffff);
   endtask

   task automatic test_random(input int count);
      logic [2:0]  mode;
      logic [63:0] v;
      logic [12:0] dexp;
      for (int i = 0; i < count; i++) begin
         mode = 3'($urandom_range(7));
         v = rand64();
         case ($urandom_range(3))
            0: v = v >> $urandom_range(63);
            1: v = ~(v >> $urandom_range(63));
            default: ;
         endcase
         if (mode == MODE_DBL && $urandom_range(1)) begin
            dexp = 13'($urandom_range(1023 + 140, 1023 - 160));
            v = {v[63], dexp[10:0], v[51:29], 29'd0};
         end
         if (mode > MODE_STR && $urandom_range(3) != 0) mode = 3'($urandom_range(4));
         send_scalar(mode, v);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      send_idle_pct = 35;
      recv_idle_pct = 45;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(95);
      send_idle_pct = 45;
      recv_idle_pct = 35;
      test_random(95);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(95);
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_bytes.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
